// File: src/bam_pkg.sv
// shared types and constants of the bitmap allocator
`default_nettype none
package bam_pkg;

  // fixed port widths
  localparam int IN_IDX_W  = 10;
  localparam int OUT_IDX_W = 10;
  localparam int STATUS_W  = 2;
  localparam int USED_W    = 11;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FREE = 3'b100
  } state_t;

endpackage
`default_nettype wire

// File: src/bam_map_mem.sv
// usage map storage: registered-read memory with per-word valid bits
`default_nettype none
module bam_map_mem #(
  parameter int WORDS  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem_r [WORDS];
  logic [WORDS-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;

  // a word never written since reset reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: src/bam_find_zero.sv
// lowest clear bit finder for one map word
`default_nettype none
module bam_find_zero #(
  parameter int WIDTH = 32,
  parameter int POS_W = 5
) (
  input  wire logic [WIDTH-1:0] word,
  output logic                  found,
  output logic      [POS_W-1:0] pos
);

  logic [WIDTH-1:0] zeros;
  logic [WIDTH-1:0] lowest;

  // isolate the lowest clear bit, then encode its position
  assign zeros  = ~word;
  assign lowest = zeros & (~zeros + WIDTH'(1));
  assign found  = |zeros;

  always_comb begin
    pos = '0;
    for (int k = 0; k < POS_W; k++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (i[k]) begin
          pos[k] = pos[k] | lowest[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/bitmap_allocator_with_hint_unit.sv
// bitmap allocator with low-water search hint, top level
`default_nettype none
// usage
//   a request is taken at a rising edge with start high and busy low; in_mode
//   selects allocate (lowest free entry at or after the hint's word) or free
//   (release in_entry_index)
//   each request yields exactly one result, held on out_granted_index,
//   out_status and out_used_entries for one cycle while out_strobe is high;
//   the receiver cannot hold results off, so none is ever dropped
// timing
//   a free of an out-of-range entry, or an allocate with the hint past the last
//   word, answers in the cycle after the request
//   a free reads the map word that holds in_entry_index and answers from ST_FREE
//   an allocate reads one word per cycle from the hint's word onward, at most up
//   to the last map word, and answers from ST_SCAN on the first word with a clear
//   bit or on the full last word; the map's single read port sets this rate
//   busy is high from the request until the result; the next request can be
//   taken in the cycle the result is shown
// reset
//   synchronous active-low reset empties the map at once through per-word
//   valid bits, and clears hint and count; no clearing pass
// WORD_BITS is a power of two
module bitmap_allocator_with_hint_unit #(
  parameter int MAP_ENTRIES = 1024,
  parameter int WORD_BITS   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_mode,
  input  wire logic [bam_pkg::IN_IDX_W-1:0]  in_entry_index,
  output logic                               out_strobe,
  output logic      [bam_pkg::OUT_IDX_W-1:0] out_granted_index,
  output logic      [bam_pkg::STATUS_W-1:0]  out_status,
  output logic      [bam_pkg::USED_W-1:0]    out_used_entries
);

  localparam int MAP_WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int HINT_W    = $clog2(MAP_ENTRIES + 1);
  localparam int EXT_W     = HINT_W + bam_pkg::USED_W + bam_pkg::IN_IDX_W;

  localparam logic [WADDR_W-1:0]   LAST_WORD = WADDR_W'(MAP_WORDS - 1);
  // bits past the pool end in the last word count as taken
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (MAP_WORDS * WORD_BITS - MAP_ENTRIES);
  localparam logic [EXT_W-1:0]     ENTRIES_EXT = EXT_W'(MAP_ENTRIES);
  localparam logic [HINT_W-1:0]    WORDS_HINT  = HINT_W'(MAP_WORDS);
  localparam logic [HINT_W-1:0]    ENTRIES_HINT = HINT_W'(MAP_ENTRIES);

  bam_pkg::state_t state_r, state_nxt;

  logic [HINT_W-1:0]  hint_r, hint_nxt;
  logic [HINT_W-1:0]  used_r, used_nxt;
  logic [HINT_W-1:0]  req_idx_r, req_idx_nxt;
  logic [WADDR_W-1:0] scan_w_r, scan_w_nxt;

  logic                          out_strobe_r, out_strobe_nxt;
  logic [bam_pkg::OUT_IDX_W-1:0] out_granted_r, out_granted_nxt;
  logic [bam_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [bam_pkg::USED_W-1:0]    out_used_r, out_used_nxt;

  // map port
  logic                 mem_rd_en;
  logic [WADDR_W-1:0]   mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [WADDR_W-1:0]   mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;

  // scan path
  logic [WORD_BITS-1:0]     word_mask;
  logic [WORD_BITS-1:0]     scan_word;
  logic                     zero_found;
  logic [BIT_W-1:0]         zero_pos;
  logic [WADDR_W+BIT_W-1:0] grant_cat;
  logic [HINT_W-1:0]        grant_idx;

  // request decode and width conversion
  logic [EXT_W-1:0]  idx_ext;
  logic [HINT_W-1:0] hint_word;
  logic [BIT_W-1:0]  free_bit;
  logic              free_bit_set;
  logic [EXT_W-1:0]  grant_ext;
  logic [EXT_W-1:0]  used_ext;

  bam_map_mem #(
    .WORDS  (MAP_WORDS),
    .WIDTH  (WORD_BITS),
    .ADDR_W (WADDR_W)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign word_mask = (scan_w_r == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}};
  assign scan_word = mem_rd_data | ~word_mask;

  bam_find_zero #(
    .WIDTH (WORD_BITS),
    .POS_W (BIT_W)
  ) u_find (
    .word  (scan_word),
    .found (zero_found),
    .pos   (zero_pos)
  );

  assign grant_cat    = {scan_w_r, zero_pos};
  assign grant_idx    = HINT_W'(grant_cat);
  assign idx_ext      = EXT_W'(in_entry_index);
  assign hint_word    = hint_r >> BIT_W;
  assign free_bit     = req_idx_r[BIT_W-1:0];
  assign free_bit_set = mem_rd_data[free_bit];
  assign grant_ext    = EXT_W'(grant_idx);
  assign used_ext     = EXT_W'(used_nxt);

  assign busy = (state_r != bam_pkg::ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    hint_nxt        = hint_r;
    used_nxt        = used_r;
    req_idx_nxt     = req_idx_r;
    scan_w_nxt      = scan_w_r;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = scan_w_r;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = scan_w_r;
    mem_wr_data     = mem_rd_data;
    out_strobe_nxt  = 1'b0;
    out_granted_nxt = '0;
    out_status_nxt  = bam_pkg::STATUS_OK;

    unique case (state_r)
      bam_pkg::ST_IDLE: begin
        if (start) begin
          if (in_mode == bam_pkg::MODE_FREE) begin
            if (idx_ext >= ENTRIES_EXT) begin
              // out of range: answer at once, nothing changes
              out_strobe_nxt = 1'b1;
              out_status_nxt = bam_pkg::STATUS_BAD_FREE;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = idx_ext[BIT_W +: WADDR_W];
              req_idx_nxt = idx_ext[HINT_W-1:0];
              state_nxt   = bam_pkg::ST_FREE;
            end
          end else begin
            if (hint_word >= WORDS_HINT) begin
              // hint past the last word: pool full
              out_strobe_nxt = 1'b1;
              out_status_nxt = bam_pkg::STATUS_FULL;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = hint_r[BIT_W +: WADDR_W];
              scan_w_nxt  = hint_r[BIT_W +: WADDR_W];
              state_nxt   = bam_pkg::ST_SCAN;
            end
          end
        end
      end

      bam_pkg::ST_SCAN: begin
        if (zero_found) begin
          mem_wr_en       = 1'b1;
          mem_wr_addr     = scan_w_r;
          mem_wr_data     = mem_rd_data | (WORD_BITS'(1) << zero_pos);
          used_nxt        = used_r + HINT_W'(1);
          hint_nxt        = grant_idx + HINT_W'(1);
          out_strobe_nxt  = 1'b1;
          out_granted_nxt = grant_ext[bam_pkg::OUT_IDX_W-1:0];
          state_nxt       = bam_pkg::ST_IDLE;
        end else if (scan_w_r == LAST_WORD) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = bam_pkg::STATUS_FULL;
          state_nxt      = bam_pkg::ST_IDLE;
        end else begin
          // word is full, fetch the next one
          mem_rd_en   = 1'b1;
          mem_rd_addr = scan_w_r + WADDR_W'(1);
          scan_w_nxt  = scan_w_r + WADDR_W'(1);
        end
      end

      bam_pkg::ST_FREE: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = bam_pkg::ST_IDLE;
        if (!free_bit_set) begin
          out_status_nxt = bam_pkg::STATUS_BAD_FREE;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = req_idx_r[BIT_W +: WADDR_W];
          mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << free_bit);
          if (used_r != '0) begin
            used_nxt = used_r - HINT_W'(1);
          end
          if (req_idx_r < hint_r) begin
            hint_nxt = req_idx_r;
          end
        end
      end

      default: begin
        state_nxt = bam_pkg::ST_IDLE;
      end
    endcase

    out_used_nxt = used_ext[bam_pkg::USED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bam_pkg::ST_IDLE;
      hint_r       <= '0;
      used_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hint_r       <= hint_nxt;
      used_r       <= used_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_idx_r     <= req_idx_nxt;
    scan_w_r      <= scan_w_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_used_r    <= out_used_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_granted_index = out_granted_r;
  assign out_status        = out_status_r;
  assign out_used_entries  = out_used_r;

  // a taken request either answers next cycle or keeps the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("request neither answered nor in progress");

  // an error result leaves the used count alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != bam_pkg::STATUS_OK) |-> (used_r == $past(used_r)))
    else $error("error result changed the used count");

  // count and hint never pass the pool size
  assert property (@(posedge clk) disable iff (!rst_n)
    (used_r <= ENTRIES_HINT) && (hint_r <= ENTRIES_HINT))
    else $error("used count or hint beyond pool size");

endmodule
`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for the bitmap allocator with search hint
module testbench;
  import bam_pkg::*;

  // pool geometry, matching the defaults of the block
  localparam int MAP_ENTRIES = 1024;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  // cycles with neither a request nor a result before the run is declared hung
  localparam int HANG_LIMIT  = 1000;
  // quiet cycles after the last result, a bit more than the longest scan
  localparam int DRAIN_CYCLES = 40;

  // one result of the block
  typedef struct packed {
    logic [OUT_IDX_W-1:0] granted;
    logic [STATUS_W-1:0]  status;
    logic [USED_W-1:0]    used;
  } alloc_result_t;

  // one row of the directed table; pinned rows carry their result typed in
  typedef struct {
    logic                mode;
    logic [IN_IDX_W-1:0] idx;
    logic                pinned;
    alloc_result_t       result;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_mode;
  logic [IN_IDX_W-1:0]   in_entry_index;
  logic                  out_strobe;
  logic [OUT_IDX_W-1:0]  out_granted_index;
  logic [STATUS_W-1:0]   out_status;
  logic [USED_W-1:0]     out_used_entries;

  // shadow copy of the allocator state
  logic [MAP_ENTRIES-1:0] shadow_map;
  int                     shadow_hint;
  int                     shadow_used;

  // results still owed by the block, oldest first
  alloc_result_t pending_results[$];
  // typed-in result that goes with the request now on the ports
  logic          pin_req;
  alloc_result_t pin_result;

  int req_count;
  int quiet_cycles;
  int fail_count;
  int idle_pct;

  directed_row_t directed_rows[$];

  bitmap_allocator_with_hint_unit #(
    .MAP_ENTRIES(MAP_ENTRIES),
    .WORD_BITS  (WORD_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_entry_index   (in_entry_index),
    .out_strobe       (out_strobe),
    .out_granted_index(out_granted_index),
    .out_status       (out_status),
    .out_used_entries (out_used_entries)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // work out the result of one request and move the shadow state along
  function automatic alloc_result_t grant_or_release(logic mode, logic [IN_IDX_W-1:0] idx);
    alloc_result_t r;
    int            w;
    int            b;
    int            pos;
    bit            found;
    r.granted = '0;
    r.status  = STATUS_OK;
    found     = 1'b0;
    if (mode == MODE_ALLOC) begin
      // scan starts at bit 0 of the word that holds the hint, so lower bits count too
      for (w = shadow_hint / WORD_BITS; w < MAP_WORDS && !found; w++) begin
        for (b = 0; b < WORD_BITS && !found; b++) begin
          pos = w * WORD_BITS + b;
          // bits past the pool end are never handed out
          if (pos < MAP_ENTRIES && !shadow_map[pos]) begin
            shadow_map[pos] = 1'b1;
            shadow_used++;
            shadow_hint = pos + 1;
            r.granted   = OUT_IDX_W'(pos);
            found       = 1'b1;
          end
        end
      end
      // nothing clear from the hint's word on: pool full, state untouched
      if (!found) r.status = STATUS_FULL;
    end else begin
      // release of an out-of-range or already clear entry is refused
      if (int'(idx) >= MAP_ENTRIES || !shadow_map[idx]) begin
        r.status = STATUS_BAD_FREE;
      end else begin
        shadow_map[idx] = 1'b0;
        if (shadow_used > 0) shadow_used--;
        // low-water hint follows the freed entry down
        if (int'(idx) < shadow_hint) shadow_hint = int'(idx);
      end
    end
    r.used = USED_W'(shadow_used);
    return r;
  endfunction

  // an allocated entry near a random spot, or any entry if the pool is empty
  function automatic logic [IN_IDX_W-1:0] pick_used_entry();
    int base;
    int k;
    int pos;
    base = $urandom_range(MAP_ENTRIES - 1);
    for (k = 0; k < MAP_ENTRIES; k++) begin
      pos = (base + k) % MAP_ENTRIES;
      if (shadow_map[pos]) return IN_IDX_W'(pos);
    end
    return IN_IDX_W'(base);
  endfunction

  // monitor: results are checked before the request of the same edge is taken
  always @(posedge clk) begin : monitor
    alloc_result_t want;
    alloc_result_t got;
    bit            moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_strobe) begin
        moved         = 1'b1;
        got.granted   = out_granted_index;
        got.status    = out_status;
        got.used      = out_used_entries;
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request waiting: granted %0d status %0d used %0d",
                   $time, got.granted, got.status, got.used);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.granted !== want.granted) begin
            $display("%0t: granted_index expected %0d got %0d", $time, want.granted,
                     got.granted);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.used !== want.used) begin
            $display("%0t: used_entries expected %0d got %0d", $time, want.used, got.used);
            fail_count++;
          end
        end
      end
      // request taken on this edge
      if (start && !busy) begin
        moved = 1'b1;
        want  = grant_or_release(in_mode, in_entry_index);
        // a typed-in row is checked against its own figures, the shadow still tracks it
        if (pin_req) want = pin_result;
        pending_results.push_back(want);
        req_count++;
      end
      // watchdog on handshake activity
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // drive one request, with random idle cycles ahead of it, and wait until taken
  task automatic issue_request(logic mode, logic [IN_IDX_W-1:0] idx, logic pinned,
                               alloc_result_t pin);
    int seen;
    while ($urandom_range(99) < idle_pct) begin
      start          <= 1'b0;
      in_mode        <= 1'($urandom_range(1));
      in_entry_index <= IN_IDX_W'($urandom_range(MAP_ENTRIES - 1));
      @(negedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_entry_index <= idx;
    pin_req        <= pinned;
    pin_result     <= pin;
    seen = req_count;
    do @(negedge clk); while (req_count == seen);
  endtask

  // random mix of allocations and releases; releases mostly pick live entries
  task automatic run_mixed(int count, int alloc_pct);
    int            n;
    alloc_result_t none;
    none = '0;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < alloc_pct)
        issue_request(MODE_ALLOC, IN_IDX_W'($urandom_range(MAP_ENTRIES - 1)), 1'b0, none);
      else if ($urandom_range(99) < 80)
        issue_request(MODE_FREE, pick_used_entry(), 1'b0, none);
      else
        issue_request(MODE_FREE, IN_IDX_W'($urandom_range(MAP_ENTRIES - 1)), 1'b0, none);
    end
  endtask

  initial begin : stimulus
    alloc_result_t none;
    int            n;
    none           = '0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = MODE_ALLOC;
    in_entry_index = '0;
    pin_req        = 1'b0;
    pin_result     = '0;
    shadow_map     = '0;
    shadow_hint    = 0;
    shadow_used    = 0;
    req_count      = 0;
    quiet_cycles   = 0;
    fail_count     = 0;
    idle_pct       = 35;

    // directed table: mode, index, pinned, {granted, status, used}
    // first grants after reset come from the bottom of the pool
    directed_rows.push_back('{MODE_ALLOC, 10'd0,    1'b1, '{10'd0, STATUS_OK,       11'd1}});
    directed_rows.push_back('{MODE_ALLOC, 10'd1023, 1'b1, '{10'd1, STATUS_OK,       11'd2}});
    // release of a clear entry at the top index
    directed_rows.push_back('{MODE_FREE,  10'd1023, 1'b1, '{10'd0, STATUS_BAD_FREE, 11'd2}});
    directed_rows.push_back('{MODE_FREE,  10'd0,    1'b1, '{10'd0, STATUS_OK,       11'd1}});
    // hint pulled back to zero, so entry 0 comes back
    directed_rows.push_back('{MODE_ALLOC, 10'd0,    1'b1, '{10'd0, STATUS_OK,       11'd2}});
    directed_rows.push_back('{MODE_FREE,  10'd1,    1'b1, '{10'd0, STATUS_OK,       11'd1}});
    // double release
    directed_rows.push_back('{MODE_FREE,  10'd1,    1'b1, '{10'd0, STATUS_BAD_FREE, 11'd1}});
    directed_rows.push_back('{MODE_ALLOC, 10'd0,    1'b1, '{10'd1, STATUS_OK,       11'd2}});
    directed_rows.push_back('{MODE_ALLOC, 10'd0,    1'b0, none});
    directed_rows.push_back('{MODE_ALLOC, 10'd1023, 1'b0, none});
    directed_rows.push_back('{MODE_ALLOC, 10'd0,    1'b0, none});
    // hole in the middle of a run, refilled by the next grant
    directed_rows.push_back('{MODE_FREE,  10'd3,    1'b0, none});
    directed_rows.push_back('{MODE_ALLOC, 10'd0,    1'b0, none});
    // releases of clear entries with alternating index bits and at word edges, then of a live one
    directed_rows.push_back('{MODE_FREE,  10'h2AA,  1'b1, '{10'd0, STATUS_BAD_FREE, 11'd5}});
    directed_rows.push_back('{MODE_FREE,  10'h155,  1'b1, '{10'd0, STATUS_BAD_FREE, 11'd5}});
    directed_rows.push_back('{MODE_FREE,  10'd512,  1'b0, none});
    directed_rows.push_back('{MODE_FREE,  10'd31,   1'b0, none});
    directed_rows.push_back('{MODE_FREE,  10'd32,   1'b0, none});
    directed_rows.push_back('{MODE_FREE,  10'd2,    1'b0, none});
    directed_rows.push_back('{MODE_ALLOC, 10'd0,    1'b0, none});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase one: sender idles often
    foreach (directed_rows[row])
      issue_request(directed_rows[row].mode, directed_rows[row].idx,
                    directed_rows[row].pinned, directed_rows[row].result);
    run_mixed(200, 65);

    // phase two: sender idles more; fill the pool, then run into pool full
    idle_pct = 57;
    while (shadow_used < MAP_ENTRIES)
      issue_request(MODE_ALLOC, IN_IDX_W'($urandom_range(MAP_ENTRIES - 1)), 1'b0, none);
    for (n = 0; n < 8; n++)
      issue_request(MODE_ALLOC, IN_IDX_W'($urandom_range(MAP_ENTRIES - 1)), 1'b0, none);
    // top entry freed and granted again leaves the hint past the last word
    issue_request(MODE_FREE, 10'd1023, 1'b0, none);
    issue_request(MODE_ALLOC, 10'd0, 1'b0, none);
    issue_request(MODE_ALLOC, 10'd0, 1'b0, none);
    run_mixed(60, 50);

    // phase three: back-to-back requests, draining the pool
    idle_pct = 0;
    run_mixed(200, 35);

    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: bitmap_allocator_with_hint_unit.f
src/bam_pkg.sv
src/bam_map_mem.sv
src/bam_find_zero.sv
src/bitmap_allocator_with_hint_unit.sv
dv/testbench.sv
